### sv/grid_trilinear_sampler_defines.svh
// assertion macros for the checker file
`ifndef GRID_TRILINEAR_SAMPLER_DEFINES_SVH
`define GRID_TRILINEAR_SAMPLER_DEFINES_SVH

// checked on every edge, reset included
`define GTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only while out of reset
`define GTS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

### sv/gts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gts_pkg;

    // field widths
    localparam int CELL_XY_W  = 7;
    localparam int CELL_Z_W   = 5;
    localparam int VALUE_W    = 16;
    localparam int POINT_XY_W = 9;
    localparam int POINT_Z_W  = 7;

    localparam int GRID_XY_DEF = 128;
    localparam int GRID_Z_DEF  = 32;

    // fine steps per grid cell, and the bits of the weight
    localparam int SPACING = 4;
    localparam int WW      = $clog2(SPACING);

    localparam logic [VALUE_W-1:0] ONE_VALUE = 16'd32768;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // microprogram
    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] ST_IDLE  = PC_W'(0);
    localparam logic [PC_W-1:0] ST_OFFS  = PC_W'(1);
    localparam logic [PC_W-1:0] ST_WRITE = PC_W'(2);
    localparam logic [PC_W-1:0] ST_RD0   = PC_W'(3);
    localparam logic [PC_W-1:0] ST_RD1   = PC_W'(4);
    localparam logic [PC_W-1:0] ST_RD2   = PC_W'(5);
    localparam logic [PC_W-1:0] ST_RD3   = PC_W'(6);
    localparam logic [PC_W-1:0] ST_RD4   = PC_W'(7);
    localparam logic [PC_W-1:0] ST_RD5   = PC_W'(8);
    localparam logic [PC_W-1:0] ST_RD6   = PC_W'(9);
    localparam logic [PC_W-1:0] ST_RD7   = PC_W'(10);
    localparam logic [PC_W-1:0] ST_LX    = PC_W'(11);
    localparam logic [PC_W-1:0] ST_LY    = PC_W'(12);
    localparam logic [PC_W-1:0] ST_LZ    = PC_W'(13);

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_IF_SAMPLE,
        JMP_GOTO,
        JMP_WAIT_OUT
    } t_jump;

    typedef enum logic [1:0] {
        LS_A_RD,
        LS_L0_L1,
        LS_L1_L2
    } t_lsrc;

    typedef enum logic [1:0] {
        WS_X,
        WS_Y,
        WS_Z
    } t_wsel;

    typedef enum logic [1:0] {
        LD_L0,
        LD_L1,
        LD_L2,
        LD_OUT
    } t_ldst;

    // corner bit 0 picks x1, bit 1 picks y1, bit 2 picks z1
    typedef struct packed {
        logic            mem_we;
        logic            mem_re;
        logic [2:0]      corner;
        logic            load_a;
        logic            load_offs;
        logic            lerp_en;
        t_lsrc           lsrc;
        t_wsel           wsel;
        t_ldst           ldst;
        t_jump           jump;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c        = '0;
        c.lsrc   = LS_A_RD;
        c.wsel   = WS_X;
        c.ldst   = LD_L0;
        c.jump   = JMP_NEXT;
        c.target = ST_IDLE;
        case (pc)
            ST_IDLE: begin
                c.jump   = JMP_WAIT_IN;
                c.target = ST_OFFS;
            end
            ST_OFFS: begin
                c.load_offs = 1'b1;
                c.jump      = JMP_IF_SAMPLE;
                c.target    = ST_RD0;
            end
            ST_WRITE: begin
                c.mem_we = 1'b1;
                c.jump   = JMP_GOTO;
            end
            ST_RD0: begin
                c.mem_re = 1'b1;
                c.corner = 3'b000;
            end
            ST_RD1: begin
                c.mem_re = 1'b1;
                c.corner = 3'b001;
                c.load_a = 1'b1;
            end
            ST_RD2: begin
                c.mem_re  = 1'b1;
                c.corner  = 3'b010;
                c.lerp_en = 1'b1;
                c.ldst    = LD_L0;
            end
            ST_RD3: begin
                c.mem_re = 1'b1;
                c.corner = 3'b011;
                c.load_a = 1'b1;
            end
            ST_RD4: begin
                c.mem_re  = 1'b1;
                c.corner  = 3'b100;
                c.lerp_en = 1'b1;
                c.ldst    = LD_L1;
            end
            ST_RD5: begin
                c.mem_re  = 1'b1;
                c.corner  = 3'b101;
                c.load_a  = 1'b1;
                c.lerp_en = 1'b1;
                c.lsrc    = LS_L0_L1;
                c.wsel    = WS_Y;
                c.ldst    = LD_L0;
            end
            ST_RD6: begin
                c.mem_re  = 1'b1;
                c.corner  = 3'b110;
                c.lerp_en = 1'b1;
                c.ldst    = LD_L1;
            end
            ST_RD7: begin
                c.mem_re = 1'b1;
                c.corner = 3'b111;
                c.load_a = 1'b1;
            end
            ST_LX: begin
                c.lerp_en = 1'b1;
                c.ldst    = LD_L2;
            end
            ST_LY: begin
                c.lerp_en = 1'b1;
                c.lsrc    = LS_L1_L2;
                c.wsel    = WS_Y;
                c.ldst    = LD_L1;
            end
            ST_LZ: begin
                c.lerp_en = 1'b1;
                c.lsrc    = LS_L0_L1;
                c.wsel    = WS_Z;
                c.ldst    = LD_OUT;
                c.jump    = JMP_WAIT_OUT;
                c.target  = ST_IDLE;
            end
            default: begin
                c.jump   = JMP_GOTO;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/grid_trilinear_sampler.sv
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_stall    i_command, i_cell_x/y/z, i_cell_value,
//                                          i_point_x/y/z
// out      out  o_out_valid / i_out_stall  o_sample_value
//
// a write beat passes the offset and write states before the next accept
// in a sample beat eight reads go one per cycle through the single
// port of the grid memory and one shared lerp unit follows them
// the final lerp result is loaded into an output register
// the last step waits there only while an earlier result is still stalled
// reset clears the sequencer and output valid; grid contents are kept as garbage
`timescale 1ns / 1ps
`default_nettype none

module grid_trilinear_sampler #(
    parameter int GRID_XY = gts_pkg::GRID_XY_DEF,
    parameter int GRID_Z  = gts_pkg::GRID_Z_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_stall,
    input  wire logic                            i_command,
    input  wire logic [gts_pkg::CELL_XY_W-1:0]   i_cell_x,
    input  wire logic [gts_pkg::CELL_XY_W-1:0]   i_cell_y,
    input  wire logic [gts_pkg::CELL_Z_W-1:0]    i_cell_z,
    input  wire logic [gts_pkg::VALUE_W-1:0]     i_cell_value,
    input  wire logic [gts_pkg::POINT_XY_W-1:0]  i_point_x,
    input  wire logic [gts_pkg::POINT_XY_W-1:0]  i_point_y,
    input  wire logic [gts_pkg::POINT_Z_W-1:0]   i_point_z,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output      logic [gts_pkg::VALUE_W-1:0]     o_sample_value
);
    import gts_pkg::*;

    localparam int PLANE = GRID_XY * GRID_XY;
    localparam int DEPTH = PLANE * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_XY);
    localparam int ZW    = $clog2(GRID_Z);
    localparam int BXY_W = POINT_XY_W - WW;
    localparam int BZ_W  = POINT_Z_W - WW;

    // sequencer
    logic [PC_W-1:0] r_pc, n_pc;
    t_ctrl           ctrl;
    logic            in_acc;
    logic            can_load;
    logic            out_load;

    // captured item
    logic               r_cmd;
    logic               r_wr_ok, n_wr_ok;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [XW-1:0]      r_x0, r_x1, r_y0, r_y1, n_x0, n_x1, n_y0, n_y1;
    logic [ZW-1:0]      r_z0, r_z1, n_z0, n_z1;
    logic [WW-1:0]      r_wx, r_wy, r_wz;
    logic [BXY_W-1:0]   base_x, base_y;
    logic [BZ_W-1:0]    base_z;

    // address and memory
    logic [AW-1:0]      r_yoff0, r_yoff1, r_zoff0, r_zoff1;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    // lerp datapath
    logic [VALUE_W-1:0]         r_a, r_l0, r_l1, r_l2, r_out;
    logic [VALUE_W-1:0]         lerp_a, lerp_b, lerp_q;
    logic [WW-1:0]              lerp_w;
    logic signed [VALUE_W:0]    lerp_d;
    logic signed [WW+VALUE_W+1:0] lerp_p, lerp_s;

    logic r_out_valid;

    assign ctrl       = ucode(r_pc);
    assign o_in_stall = (r_pc != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign can_load   = !r_out_valid || !i_out_stall;
    assign out_load   = ctrl.lerp_en && (ctrl.ldst == LD_OUT) && can_load;
    assign mem_we     = ctrl.mem_we && r_wr_ok;

    always_comb begin
        case (ctrl.jump)
            JMP_NEXT:      n_pc = r_pc + PC_W'(1);
            JMP_WAIT_IN:   n_pc = in_acc ? ctrl.target : r_pc;
            JMP_IF_SAMPLE: n_pc = (r_cmd == CMD_SAMPLE) ? ctrl.target : r_pc + PC_W'(1);
            JMP_GOTO:      n_pc = ctrl.target;
            JMP_WAIT_OUT:  n_pc = can_load ? ctrl.target : r_pc;
            default:       n_pc = ST_IDLE;
        endcase
    end

    // base cell, clamp and upper neighbour, or the write cell
    assign base_x = i_point_x[POINT_XY_W-1:WW];
    assign base_y = i_point_y[POINT_XY_W-1:WW];
    assign base_z = i_point_z[POINT_Z_W-1:WW];

    always_comb begin
        n_wr_ok = (32'(i_cell_x) < GRID_XY) && (32'(i_cell_y) < GRID_XY)
                  && (32'(i_cell_z) < GRID_Z);
        n_val   = (i_cell_value > ONE_VALUE) ? ONE_VALUE : i_cell_value;
        if (i_command == CMD_WRITE) begin
            n_x0 = XW'(i_cell_x);
            n_y0 = XW'(i_cell_y);
            n_z0 = ZW'(i_cell_z);
        end else begin
            n_x0 = (32'(base_x) >= GRID_XY) ? XW'(GRID_XY - 1) : XW'(base_x);
            n_y0 = (32'(base_y) >= GRID_XY) ? XW'(GRID_XY - 1) : XW'(base_y);
            n_z0 = (32'(base_z) >= GRID_Z) ? ZW'(GRID_Z - 1) : ZW'(base_z);
        end
        n_x1 = (32'(n_x0) == GRID_XY - 1) ? n_x0 : n_x0 + XW'(1);
        n_y1 = (32'(n_y0) == GRID_XY - 1) ? n_y0 : n_y0 + XW'(1);
        n_z1 = (32'(n_z0) == GRID_Z - 1) ? n_z0 : n_z0 + ZW'(1);
    end

    assign mem_addr = (ctrl.corner[2] ? r_zoff1 : r_zoff0)
                    + (ctrl.corner[1] ? r_yoff1 : r_yoff0)
                    + AW'(ctrl.corner[0] ? r_x1 : r_x0);

    // one lerp per cycle: a + floor(w * (b - a) / SPACING)
    always_comb begin
        case (ctrl.lsrc)
            LS_A_RD: begin
                lerp_a = r_a;
                lerp_b = r_rdata;
            end
            LS_L0_L1: begin
                lerp_a = r_l0;
                lerp_b = r_l1;
            end
            LS_L1_L2: begin
                lerp_a = r_l1;
                lerp_b = r_l2;
            end
            default: begin
                lerp_a = r_a;
                lerp_b = r_rdata;
            end
        endcase
        case (ctrl.wsel)
            WS_X:    lerp_w = r_wx;
            WS_Y:    lerp_w = r_wy;
            WS_Z:    lerp_w = r_wz;
            default: lerp_w = r_wx;
        endcase
        lerp_d = $signed({1'b0, lerp_b}) - $signed({1'b0, lerp_a});
        lerp_p = (WW + VALUE_W + 2)'(lerp_d)
               * (WW + VALUE_W + 2)'($signed({1'b0, lerp_w}));
        lerp_s = $signed({{(WW + 2){1'b0}}, lerp_a}) + (lerp_p >>> WW);
        lerp_q = lerp_s[VALUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_wr_ok <= n_wr_ok;
            r_val   <= n_val;
            r_x0    <= n_x0;
            r_x1    <= n_x1;
            r_y0    <= n_y0;
            r_y1    <= n_y1;
            r_z0    <= n_z0;
            r_z1    <= n_z1;
            r_wx    <= i_point_x[WW-1:0];
            r_wy    <= i_point_y[WW-1:0];
            r_wz    <= i_point_z[WW-1:0];
        end
        if (ctrl.load_offs) begin
            r_yoff0 <= AW'(32'(r_y0) * GRID_XY);
            r_yoff1 <= AW'(32'(r_y1) * GRID_XY);
            r_zoff0 <= AW'(32'(r_z0) * PLANE);
            r_zoff1 <= AW'(32'(r_z1) * PLANE);
        end
        if (ctrl.load_a) begin
            r_a <= r_rdata;
        end
        if (ctrl.lerp_en) begin
            case (ctrl.ldst)
                LD_L0:   r_l0 <= lerp_q;
                LD_L1:   r_l1 <= lerp_q;
                LD_L2:   r_l2 <= lerp_q;
                LD_OUT:  if (can_load) r_out <= lerp_q;
                default: r_l0 <= lerp_q;
            endcase
        end
    end

    // grid store, one port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_val;
        end
        if (ctrl.mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out;

endmodule

`default_nettype wire

### sv/gts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "grid_trilinear_sampler_defines.svh"

module gts_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [gts_pkg::VALUE_W-1:0] o_sample_value
);

    `GTS_ASSERT_RUN(a_out_valid_held, o_out_valid && i_out_stall |=> o_out_valid, "out beat dropped while stalled")
    `GTS_ASSERT_RUN(a_out_data_held, o_out_valid && i_out_stall |=> $stable(o_sample_value), "out beat changed while stalled")
    `GTS_ASSERT(a_reset_quiet, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")
    `GTS_ASSERT_RUN(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "took a second beat while busy")

endmodule

bind grid_trilinear_sampler gts_checker u_gts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sample_value (o_sample_value)
);

`default_nettype wire

### sim/grid_trilinear_sampler_tb.sv
`timescale 1ns / 1ps

module grid_trilinear_sampler_tb;

    import gts_pkg::*;

    localparam int GRID_XY        = GRID_XY_DEF;
    localparam int GRID_Z         = GRID_Z_DEF;
    localparam int CELL_COUNT     = GRID_XY * GRID_XY * GRID_Z;
    localparam int RANDOM_ITEMS   = 160;
    localparam int HOLDOFF_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_command;
    logic [CELL_XY_W-1:0]   i_cell_x;
    logic [CELL_XY_W-1:0]   i_cell_y;
    logic [CELL_Z_W-1:0]    i_cell_z;
    logic [VALUE_W-1:0]     i_cell_value;
    logic [POINT_XY_W-1:0]  i_point_x;
    logic [POINT_XY_W-1:0]  i_point_y;
    logic [POINT_Z_W-1:0]   i_point_z;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [VALUE_W-1:0]     o_sample_value;

    // shadow copy of the grid memory, with a flag per cell once it holds a value
    logic [VALUE_W-1:0]     grid_shadow [0:CELL_COUNT-1];
    bit                     cell_written [0:CELL_COUNT-1];
    logic [VALUE_W-1:0]     sample_expect_q [$];

    int                     fail_count = 0;
    int                     items_sent = 0;
    int                     burst_left = 0;
    bit                     no_gaps = 1'b0;
    bit                     holdoff_request = 1'b0;
    int                     idle_cycles = 0;

    grid_trilinear_sampler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_z       (i_cell_z),
        .i_cell_value   (i_cell_value),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic int cell_index(input int x, input int y, input int z);
        return z * GRID_XY * GRID_XY + y * GRID_XY + x;
    endfunction

    // corner bit 0 picks the upper x cell, bit 1 upper y, bit 2 upper z; clamped at the far edge
    function automatic int corner_cell(input logic [POINT_XY_W-1:0] px,
                                       input logic [POINT_XY_W-1:0] py,
                                       input logic [POINT_Z_W-1:0] pz, input int corner);
        int x;
        int y;
        int z;
        x = int'(px) / SPACING;
        y = int'(py) / SPACING;
        z = int'(pz) / SPACING;
        if (x > GRID_XY - 1) x = GRID_XY - 1;
        if (y > GRID_XY - 1) y = GRID_XY - 1;
        if (z > GRID_Z - 1) z = GRID_Z - 1;
        if (corner[0] && x < GRID_XY - 1) x++;
        if (corner[1] && y < GRID_XY - 1) y++;
        if (corner[2] && z < GRID_Z - 1) z++;
        return cell_index(x, y, z);
    endfunction

    // a + floor(w * (b - a) / SPACING)
    function automatic int blend_step(input int a, input int b, input int w);
        int d;
        d = w * (b - a);
        return a + (d >>> WW);
    endfunction

    function automatic logic [VALUE_W-1:0] interp_point(input logic [POINT_XY_W-1:0] px,
                                                        input logic [POINT_XY_W-1:0] py,
                                                        input logic [POINT_Z_W-1:0] pz);
        int c [8];
        int wx;
        int wy;
        int wz;
        int lo;
        int hi;
        wx = int'(px) % SPACING;
        wy = int'(py) % SPACING;
        wz = int'(pz) % SPACING;
        for (int k = 0; k < 8; k++)
            c[k] = int'(grid_shadow[corner_cell(px, py, pz, k)]);
        lo = blend_step(blend_step(c[0], c[1], wx), blend_step(c[2], c[3], wx), wy);
        hi = blend_step(blend_step(c[4], c[5], wx), blend_step(c[6], c[7], wx), wy);
        return VALUE_W'(blend_step(lo, hi, wz));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_cell_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_VALUE;
            2: return VALUE_W'($urandom_range(32769, 65535));
            3: return '1;
            default: return VALUE_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("%0t ns mismatch: %s, expected %0d got %0d", $time, what, expected, got);
        fail_count++;
    endtask

    // offers one beat, waits for the handshake and updates the shadow state on accept
    task automatic send_beat(input logic cmd,
                             input logic [CELL_XY_W-1:0] cx, input logic [CELL_XY_W-1:0] cy,
                             input logic [CELL_Z_W-1:0] cz, input logic [VALUE_W-1:0] cv,
                             input logic [POINT_XY_W-1:0] px, input logic [POINT_XY_W-1:0] py,
                             input logic [POINT_Z_W-1:0] pz);
        int gap;
        logic [VALUE_W-1:0] stored;
        gap = 0;
        if (!no_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 15);
        end
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_cell_x     <= cx;
        i_cell_y     <= cy;
        i_cell_z     <= cz;
        i_cell_value <= cv;
        i_point_x    <= px;
        i_point_y    <= py;
        i_point_z    <= pz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_WRITE) begin
            if (cx < GRID_XY && cy < GRID_XY && cz < GRID_Z) begin
                stored = (cv > ONE_VALUE) ? ONE_VALUE : cv;
                grid_shadow[cell_index(cx, cy, cz)] = stored;
                cell_written[cell_index(cx, cy, cz)] = 1'b1;
            end
        end else begin
            sample_expect_q.push_back(interp_point(px, py, pz));
        end
    endtask

    // point fields are don't-care on a write, so they carry noise
    task automatic write_cell(input int x, input int y, input int z, input logic [VALUE_W-1:0] v);
        send_beat(CMD_WRITE, CELL_XY_W'(x), CELL_XY_W'(y), CELL_Z_W'(z), v,
                  POINT_XY_W'($urandom), POINT_XY_W'($urandom), POINT_Z_W'($urandom));
    endtask

    // never sample a cell that has not been loaded
    task automatic fill_corners(input logic [POINT_XY_W-1:0] px,
                                input logic [POINT_XY_W-1:0] py,
                                input logic [POINT_Z_W-1:0] pz);
        int idx;
        for (int k = 0; k < 8; k++) begin
            idx = corner_cell(px, py, pz, k);
            if (!cell_written[idx])
                write_cell(idx % GRID_XY, (idx / GRID_XY) % GRID_XY, idx / (GRID_XY * GRID_XY),
                           pick_cell_value());
        end
    endtask

    task automatic sample_point(input logic [POINT_XY_W-1:0] px,
                                input logic [POINT_XY_W-1:0] py,
                                input logic [POINT_Z_W-1:0] pz);
        fill_corners(px, py, pz);
        send_beat(CMD_SAMPLE, CELL_XY_W'($urandom), CELL_XY_W'($urandom), CELL_Z_W'($urandom),
                  VALUE_W'($urandom), px, py, pz);
    endtask

    task automatic test_origin_cube();
        write_cell(0, 0, 0, 16'd0);
        write_cell(1, 0, 0, ONE_VALUE);
        write_cell(0, 1, 0, 16'hFFFF);
        write_cell(1, 1, 0, 16'd32767);
        write_cell(0, 0, 1, 16'd1);
        write_cell(1, 0, 1, 16'd40000);
        write_cell(0, 1, 1, 16'd12345);
        write_cell(1, 1, 1, ONE_VALUE);
        sample_point(9'd0, 9'd0, 7'd0);
        sample_point(9'd3, 9'd3, 7'd3);
        sample_point(9'd1, 9'd2, 7'd3);
        sample_point(9'd2, 9'd0, 7'd1);
    endtask

    // upper neighbours fold back onto the last cell at the far faces
    task automatic test_far_corner();
        write_cell(GRID_XY - 1, GRID_XY - 1, GRID_Z - 1, 16'hFFFF);
        sample_point('1, '1, '1);
        write_cell(GRID_XY - 1, GRID_XY - 1, GRID_Z - 1, 16'd7);
        sample_point(9'd507, 9'd510, 7'd125);
        sample_point(9'd511, 9'd0, 7'd127);
        sample_point(9'd2, 9'd511, 7'd126);
    endtask

    task automatic test_random_mix();
        int start;
        int ax;
        int ay;
        int az;
        int anchor_left;
        logic [POINT_XY_W-1:0] px;
        logic [POINT_XY_W-1:0] py;
        logic [POINT_Z_W-1:0] pz;
        start = items_sent;
        anchor_left = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (anchor_left == 0) begin
                ax = $urandom_range(0, (1 << POINT_XY_W) - 1);
                ay = $urandom_range(0, (1 << POINT_XY_W) - 1);
                az = $urandom_range(0, (1 << POINT_Z_W) - 1);
                anchor_left = $urandom_range(20, 60);
            end
            anchor_left--;
            case ($urandom_range(0, 19))
                0, 1: write_cell(((ax >> 2) + $urandom_range(0, 4)) % GRID_XY,
                                 ((ay >> 2) + $urandom_range(0, 4)) % GRID_XY,
                                 ((az >> 2) + $urandom_range(0, 2)) % GRID_Z,
                                 pick_cell_value());
                2: write_cell($urandom_range(0, GRID_XY - 1), $urandom_range(0, GRID_XY - 1),
                              $urandom_range(0, GRID_Z - 1), pick_cell_value());
                3, 4, 5, 6: sample_point(POINT_XY_W'($urandom), POINT_XY_W'($urandom),
                                         POINT_Z_W'($urandom));
                default: begin
                    // revisit the same neighborhood so cells get reused and rewritten
                    px = POINT_XY_W'(ax + $urandom_range(0, 15));
                    py = POINT_XY_W'(ay + $urandom_range(0, 15));
                    pz = POINT_Z_W'(az + $urandom_range(0, 7));
                    sample_point(px, py, pz);
                end
            endcase
        end
    endtask

    // receiver holds off while samples keep coming, so the block backs up its input
    task automatic test_backpressure();
        logic [POINT_XY_W-1:0] px [16];
        logic [POINT_XY_W-1:0] py [16];
        logic [POINT_Z_W-1:0]  pz [16];
        int ax;
        int ay;
        int az;
        ax = $urandom_range(0, 500);
        ay = $urandom_range(0, 500);
        az = $urandom_range(0, 120);
        for (int k = 0; k < 16; k++) begin
            px[k] = POINT_XY_W'(ax + $urandom_range(0, 7));
            py[k] = POINT_XY_W'(ay + $urandom_range(0, 7));
            pz[k] = POINT_Z_W'(az + $urandom_range(0, 3));
            fill_corners(px[k], py[k], pz[k]);
        end
        no_gaps = 1'b1;
        holdoff_request = 1'b1;
        for (int k = 0; k < 16; k++)
            sample_point(px[k], py[k], pz[k]);
        no_gaps = 1'b0;
    endtask

    initial begin : out_stall_driver
        int mode;
        int mode_left;
        int hold_left;
        logic stall_next;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (holdoff_request) begin
                holdoff_request = 1'b0;
                hold_left = HOLDOFF_CYCLES - 1;
                stall_next = 1'b1;
            end else begin
                case (mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 3) != 0);
                    default: stall_next = ~i_out_stall;
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [VALUE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sample_expect_q.size() == 0) begin
                report_mismatch("sample value with no sample pending", -1, o_sample_value);
            end else begin
                want = sample_expect_q.pop_front();
                if (o_sample_value !== want)
                    report_mismatch("sample_value", want, o_sample_value);
            end
        end
    end

    // counts cycles in which no beat moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns timeout, %0d samples still pending", $time, sample_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_WRITE;
        i_cell_x     <= '0;
        i_cell_y     <= '0;
        i_cell_z     <= '0;
        i_cell_value <= '0;
        i_point_x    <= '0;
        i_point_y    <= '0;
        i_point_z    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_origin_cube();
        test_far_corner();
        test_random_mix();
        test_backpressure();
        test_random_mix();

        i_in_valid <= 1'b0;
        while (sample_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
